// ===== rtl/mcst_pkg.sv =====
// shared types, sizes and codes for the multi-channel timer table
package mcst_pkg;

  localparam int MAX_TIMERS  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_ONESHOT   = 2'd0;
  localparam logic [1:0] MODE_MULTISHOT = 2'd1;
  localparam logic [1:0] MODE_PERIODIC  = 2'd2;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] period;
    logic [63:0] start_time;
    logic [31:0] shots_left;
  } entry_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
    entry_t    data;
  } mem_wr_t;

endpackage

// ===== rtl/multi_channel_software_timer.sv =====
// top level of the multi-channel timer table: command decode, scan sequencer, results
// add, query and unknown commands: one result word in the cycle after start, busy stays low
// tick: the sequencer reads one slot per cycle from the slot memory (one read port), and busy
//   stays high through the scan and the flush that follows it; fired words come out during the
//   scan, the last one at the end
// results are strobed for one cycle each; the receiver cannot stall
// synchronous active-high reset clears all active bits and the sequencer; no clearing pass
module multi_channel_software_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] now_time,
  input  logic [31:0] period,
  input  logic [1:0]  mode,
  input  logic [31:0] shots,
  input  logic [3:0]  timer_slot,
  output logic        strobe,
  output logic        accepted,
  output logic [3:0]  slot,
  output logic        active,
  output logic        fired,
  output logic        last
);
  import mcst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;

  // per-slot active bits live in flops so reset clears them at once
  logic [MAX_TIMERS-1:0] active_vec;

  // scan pipeline: idx is the slot being read, chk_idx the slot whose data is back
  slot_idx_t idx;
  slot_idx_t chk_idx;
  logic      chk_vld;
  logic [63:0] tick_now;
  logic [FIRE_CNT_W-1:0] fire_cnt;

  // one fired word is held back so the final one can carry last
  logic      pend_vld;
  slot_idx_t pend_idx;

  entry_t  rd_data;
  mem_wr_t mem_wr;

  // lowest free slot
  slot_idx_t free_idx;
  logic      free_found;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!active_vec[i]) begin
        free_idx   = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // expiry check on the entry that just came back from memory
  logic [63:0] elapsed;
  logic        expired;
  logic        hit;
  logic        retire;
  logic        add_wr;
  logic        scan_wr;

  assign elapsed = tick_now - rd_data.start_time;
  assign expired = (tick_now > rd_data.start_time) && (elapsed > {32'd0, rd_data.period});

  // a slot with the unused mode code is kept but never fires
  assign hit = chk_vld && active_vec[chk_idx] && (rd_data.mode <= MODE_PERIODIC) && expired
               && (fire_cnt < FIRE_CNT_W'(MAX_RESULTS));

  assign retire = (rd_data.mode == MODE_ONESHOT) ||
                  ((rd_data.mode == MODE_MULTISHOT) && (rd_data.shots_left == 32'd0));

  assign add_wr  = (state == ST_IDLE) && start && (kind == KIND_ADD) && free_found;
  assign scan_wr = hit && !retire;

  always_comb begin
    mem_wr = '0;
    if (add_wr) begin
      mem_wr.en              = 1'b1;
      mem_wr.addr            = free_idx;
      mem_wr.data.mode       = mode;
      mem_wr.data.period     = period;
      mem_wr.data.start_time = now_time;
      mem_wr.data.shots_left = shots;
    end else if (scan_wr) begin
      // restart: new start time, one shot used up for multi-shot timers
      mem_wr.en              = 1'b1;
      mem_wr.addr            = chk_idx;
      mem_wr.data            = rd_data;
      mem_wr.data.start_time = tick_now;
      if (rd_data.mode == MODE_MULTISHOT) begin
        mem_wr.data.shots_left = rd_data.shots_left - 32'd1;
      end
    end
  end

  mcst_slot_ram u_slot_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active_vec <= '0;
      strobe     <= 1'b0;
      chk_vld    <= 1'b0;
      pend_vld   <= 1'b0;
      idx        <= '0;
      fire_cnt   <= '0;
    end else begin
      strobe  <= 1'b0;
      chk_vld <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (start) begin
            strobe   <= 1'b1;
            accepted <= 1'b0;
            slot     <= 4'd0;
            active   <= 1'b0;
            fired    <= 1'b0;
            last     <= 1'b1;
            case (kind)
              KIND_ADD: begin
                if (free_found) begin
                  accepted             <= 1'b1;
                  slot                 <= 4'(free_idx);
                  active_vec[free_idx] <= 1'b1;
                end
              end
              KIND_QUERY: begin
                slot <= timer_slot;
                if (32'(timer_slot) < MAX_TIMERS) begin
                  active <= active_vec[SLOT_W'(timer_slot)];
                end
              end
              KIND_TICK: begin
                // no word yet; the scan decides what comes out
                strobe   <= 1'b0;
                tick_now <= now_time;
                idx      <= '0;
                fire_cnt <= '0;
                pend_vld <= 1'b0;
                state    <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end

        ST_SCAN: begin
          chk_vld <= 1'b1;
          chk_idx <= idx;
          idx     <= idx + slot_idx_t'(1);
          if (idx == SLOT_W'(MAX_TIMERS - 1)) begin
            state <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          // wait for the final slot check, then close out the tick
          if (!chk_vld) begin
            strobe   <= 1'b1;
            accepted <= 1'b0;
            active   <= 1'b0;
            last     <= 1'b1;
            fired    <= pend_vld;
            slot     <= pend_vld ? 4'(pend_idx) : 4'd0;
            pend_vld <= 1'b0;
            idx      <= '0;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (hit) begin
        fire_cnt <= fire_cnt + FIRE_CNT_W'(1);
        if (pend_vld) begin
          strobe   <= 1'b1;
          accepted <= 1'b0;
          active   <= 1'b0;
          fired    <= 1'b1;
          last     <= 1'b0;
          slot     <= 4'(pend_idx);
        end
        pend_vld <= 1'b1;
        pend_idx <= chk_idx;
        if (retire) begin
          active_vec[chk_idx] <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // an add write and a scan write-back never compete for the write port
  a_wr_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(add_wr && scan_wr))
    else $error("add and scan write in the same cycle");

  // the word that ends a command only shows once the sequencer is back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (state == ST_IDLE))
    else $error("final word while the sequencer is still running");

  // an accepted tick always starts the scan
  a_tick_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_TICK)) |=> (state == ST_SCAN))
    else $error("tick did not start the scan");

  // memory data is only checked while a tick is in progress
  a_chk_busy: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state != ST_IDLE))
    else $error("slot check outside a scan");

  // never more fired words than one tick may report
  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FIRE_CNT_W'(MAX_RESULTS))
    else $error("fire count past limit");
`endif

endmodule

// ===== rtl/mcst_slot_ram.sv =====
// timer slot memory, one write port and one registered read port
module mcst_slot_ram (
  input  logic             clk,
  input  mcst_pkg::mem_wr_t wr,
  input  mcst_pkg::slot_idx_t rd_addr,
  output mcst_pkg::entry_t  rd_data
);
  import mcst_pkg::*;

  entry_t mem [MAX_TIMERS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== bench/mcst_tb_pkg.sv =====
// command and result word types plus the timer table scoreboard for the testbench
`timescale 1ns / 100ps
package mcst_tb_pkg;
  import mcst_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] now_time;
    logic [31:0] period;
    logic [1:0]  mode;
    logic [31:0] shots;
    logic [3:0]  timer_slot;
  } cmd_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] slot;
    logic       active;
    logic       fired;
    logic       last;
  } word_t;

  class timer_table_checker;
    bit          slot_on     [MAX_TIMERS];
    logic [1:0]  slot_mode   [MAX_TIMERS];
    logic [31:0] slot_period [MAX_TIMERS];
    logic [63:0] slot_since  [MAX_TIMERS];
    logic [31:0] slot_shots  [MAX_TIMERS];
    word_t       pending_words[$];
    int          mismatches;

    function new();
      foreach (slot_on[i]) slot_on[i] = 1'b0;
      mismatches = 0;
    endfunction

    // expected words for one accepted command, table state updated as the block would
    function void log_command(cmd_t c);
      int          fires;
      int          free_idx;
      logic        act;
      logic [64:0] due;
      fires    = 0;
      free_idx = -1;
      act      = 1'b0;
      case (c.kind)
        KIND_ADD: begin
          for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!slot_on[i]) free_idx = i;
          end
          if (free_idx < 0) begin
            pending_words.push_back('{1'b0, 4'd0, 1'b0, 1'b0, 1'b1});
          end else begin
            slot_on[free_idx]     = 1'b1;
            slot_mode[free_idx]   = c.mode;
            slot_period[free_idx] = c.period;
            slot_since[free_idx]  = c.now_time;
            slot_shots[free_idx]  = c.shots;
            pending_words.push_back('{1'b1, 4'(free_idx), 1'b0, 1'b0, 1'b1});
          end
        end
        KIND_QUERY: begin
          if (int'(c.timer_slot) < MAX_TIMERS) act = slot_on[c.timer_slot];
          pending_words.push_back('{1'b0, c.timer_slot, act, 1'b0, 1'b1});
        end
        KIND_TICK: begin
          for (int i = 0; i < MAX_TIMERS && fires < MAX_RESULTS; i++) begin
            if (slot_on[i] && slot_mode[i] <= MODE_PERIODIC) begin
              // exact sum, no wrap
              due = {1'b0, slot_since[i]} + {33'd0, slot_period[i]};
              if ({1'b0, c.now_time} > due) begin
                pending_words.push_back('{1'b0, 4'(i), 1'b0, 1'b1, 1'b0});
                fires++;
                if (slot_mode[i] == MODE_ONESHOT ||
                    (slot_mode[i] == MODE_MULTISHOT && slot_shots[i] == 32'd0)) begin
                  slot_on[i] = 1'b0;
                end else begin
                  if (slot_mode[i] == MODE_MULTISHOT) slot_shots[i]--;
                  slot_since[i] = c.now_time;
                end
              end
            end
          end
          if (fires == 0) begin
            pending_words.push_back('{1'b0, 4'd0, 1'b0, 1'b0, 1'b1});
          end else begin
            pending_words[pending_words.size() - 1].last = 1'b1;
          end
        end
        default: begin
          pending_words.push_back('{1'b0, 4'd0, 1'b0, 1'b0, 1'b1});
        end
      endcase
    endfunction

    function void compare(string field, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(logic acc, logic [3:0] s, logic act, logic fir, logic lst);
      word_t want;
      if (pending_words.size() == 0) begin
        $error("result word with nothing pending: slot %0h fired %0b last %0b", s, fir, lst);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        compare("accepted", 4'(want.accepted), 4'(acc));
        compare("slot", want.slot, s);
        compare("active", 4'(want.active), 4'(act));
        compare("fired", 4'(want.fired), 4'(fir));
        compare("last", 4'(want.last), 4'(lst));
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_multi_channel_software_timer.sv =====
// testbench top for the multi-channel timer table: directed and random commands, scoreboard
`timescale 1ns / 100ps
module tb_multi_channel_software_timer;
  import mcst_pkg::*;
  import mcst_tb_pkg::*;

  localparam int RANDOM_CMDS = 250;
  // base time of the directed part, a later start time for its far timers, and start of the random time line
  localparam logic [63:0] BASE_TIME = 64'd1000;
  localparam logic [63:0] FAR_TIME  = 64'h1_0000_1000;
  localparam logic [63:0] RUN_START = 64'h2_0000_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = 2'd0;
  logic [63:0] now_time = 64'd0;
  logic [31:0] period = 32'd0;
  logic [1:0]  mode = 2'd0;
  logic [31:0] shots = 32'd0;
  logic [3:0]  timer_slot = 4'd0;
  logic        busy;
  logic        strobe;
  logic        accepted;
  logic [3:0]  slot;
  logic        active;
  logic        fired;
  logic        last;

  timer_table_checker chk;

  // burst state of the command sender
  int burst_left = 0;
  // timers that may never retire (periodic, unused mode, huge shot count, far start)
  int stuck_timers = 0;
  logic [63:0] cur_time;

  multi_channel_software_timer u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .now_time   (now_time),
    .period     (period),
    .mode       (mode),
    .shots      (shots),
    .timer_slot (timer_slot),
    .strobe     (strobe),
    .accepted   (accepted),
    .slot       (slot),
    .active     (active),
    .fired      (fired),
    .last       (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #200_000;
    $display("FAILURE");
    $finish;
  end

  // sample at the rising edge: result words first, then the command taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) chk.check_word(accepted, slot, active, fired, last);
      if (start && !busy) chk.log_command('{kind, now_time, period, mode, shots, timer_slot});
    end
  end

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.kind       = 2'($urandom_range(0, 3));
    c.now_time   = {$urandom, $urandom};
    c.period     = $urandom;
    c.mode       = 2'($urandom_range(0, 3));
    c.shots      = $urandom;
    c.timer_slot = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // drive one command at the falling edge, hold it until the block takes it
  task automatic issue_command(input cmd_t c);
    int gap;
    @(negedge clk);
    start      = 1'b1;
    kind       = c.kind;
    now_time   = c.now_time;
    period     = c.period;
    mode       = c.mode;
    shots      = c.shots;
    timer_slot = c.timer_slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic add_timer(input logic [63:0] t, input logic [31:0] p, input logic [1:0] m,
                           input logic [31:0] n);
    cmd_t c;
    c          = noise_cmd();
    c.kind     = KIND_ADD;
    c.now_time = t;
    c.period   = p;
    c.mode     = m;
    c.shots    = n;
    issue_command(c);
  endtask

  task automatic tick_at(input logic [63:0] t);
    cmd_t c;
    c          = noise_cmd();
    c.kind     = KIND_TICK;
    c.now_time = t;
    issue_command(c);
  endtask

  task automatic query_slot(input logic [3:0] s);
    cmd_t c;
    c            = noise_cmd();
    c.kind       = KIND_QUERY;
    c.timer_slot = s;
    issue_command(c);
  endtask

  initial begin
    cmd_t        c;
    logic [1:0]  m;
    logic [31:0] p;
    logic [31:0] n;
    logic [63:0] t;
    int          pick;
    int          waited;
    chk = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table query on the highest slot, and an unknown command with every bit set
    query_slot(4'hF);
    issue_command('{KIND_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd3,
                    32'hFFFF_FFFF, 4'hF});

    // fill the whole table; period extremes, a zero-shot and a huge-shot multi-shot timer
    for (int i = 0; i < MAX_TIMERS; i++) begin
      p = (i == MAX_TIMERS - 1) ? 32'hFFFF_FFFF : 32'(i * 3);
      m = (i == 1 || i == MAX_TIMERS - 2) ? MODE_MULTISHOT : MODE_ONESHOT;
      n = (i == MAX_TIMERS - 2) ? 32'hFFFF_FFFF : 32'd0;
      add_timer(BASE_TIME, p, m, n);
    end
    stuck_timers++;
    // table full
    add_timer(BASE_TIME, 32'd7, MODE_ONESHOT, 32'd0);
    query_slot(4'd7);
    // now equal to start: zero period timers must not fire yet
    tick_at(BASE_TIME);
    // every timer expires at once, the tick carries the most words
    tick_at(BASE_TIME + 64'h1_0000_0000);

    // a multi-shot, a periodic and an unused-mode timer, plus a timer whose deadline lies past the 64-bit range
    add_timer(FAR_TIME, 32'd5, MODE_MULTISHOT, 32'd1);
    add_timer(FAR_TIME, 32'd1, MODE_PERIODIC, 32'd0);
    add_timer(FAR_TIME, 32'd0, MODE_UNUSED, 32'd0);
    add_timer(64'hFFFF_FFFF_FFFF_FFF0, 32'h20, MODE_ONESHOT, 32'd0);
    stuck_timers += 3;
    tick_at(FAR_TIME + 64'd6);
    tick_at(64'hFFFF_FFFF_FFFF_FFFF);
    query_slot(4'd2);

    // random part: mostly timers on a rising time line, some noise
    cur_time = RUN_START;
    for (int k = 0; k < RANDOM_CMDS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) m = MODE_ONESHOT;
        else if (pick < 85) m = MODE_MULTISHOT;
        else if (pick < 95) m = MODE_PERIODIC;
        else m = MODE_UNUSED;
        if ((m == MODE_PERIODIC || m == MODE_UNUSED) && stuck_timers >= 10) m = MODE_ONESHOT;
        if (m == MODE_PERIODIC || m == MODE_UNUSED) stuck_timers++;
        n = $urandom;
        if (m == MODE_MULTISHOT) begin
          if ($urandom_range(0, 19) == 0 && stuck_timers < 10) stuck_timers++;
          else n = $urandom_range(0, 3);
        end
        p = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40);
        t = cur_time;
        // far start time, kept to one-shot since it may never expire
        if ($urandom_range(0, 29) == 0 && stuck_timers < 10) begin
          t = {$urandom, $urandom};
          if (m != MODE_ONESHOT) m = MODE_ONESHOT;
          else stuck_timers++;
        end
        add_timer(t, p, m, n);
      end else if (pick < 75) begin
        // rare big jumps let long-period timers expire too
        if ($urandom_range(0, 39) == 0) cur_time += 64'($urandom);
        else cur_time += 64'($urandom_range(0, 25));
        tick_at(cur_time);
      end else if (pick < 92) begin
        query_slot(4'($urandom_range(0, 15)));
      end else begin
        c      = noise_cmd();
        c.kind = KIND_UNKNOWN;
        issue_command(c);
      end
    end

    @(negedge clk);
    start = 1'b0;
    // drain: a tick scan is the longest wait for outstanding words
    waited = 0;
    while (chk.pending_words.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (MAX_TIMERS + 8) @(posedge clk);
    if (chk.pending_words.size() != 0)
      $error("%0d expected result words never arrived", chk.pending_words.size());
    if (chk.mismatches == 0 && chk.pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mcst_pkg.sv
rtl/mcst_slot_ram.sv
rtl/multi_channel_software_timer.sv
bench/mcst_tb_pkg.sv
bench/tb_multi_channel_software_timer.sv
